// ===== src/rcq_pkg.sv =====
// ----------------------------------------------------------------------------
// rcq_pkg: shared types and constants of the code repeat qualifier
// Field widths, register indexes, reset values and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package rcq_pkg;

  // Field widths of a decoded frame and of a report.
  localparam int PROTO_W = 8;
  localparam int CODE_W  = 32;
  localparam int BITS_W  = 7;
  localparam int PULSE_W = 16;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 8;
  localparam int SUM_W   = 24;

  // Divider operand widths: numerator is 2*sum+n, denominator is 2*n.
  localparam int DIV_NUM_W = SUM_W + 2;
  localparam int DIV_DEN_W = COUNT_W + 1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WINDOW_W    = 16;
  localparam int NEEDED_W    = 8;
  localparam int DEBOUNCE_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEATS_NEEDED = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd2;

  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 16'd200;
  localparam logic [NEEDED_W-1:0]   NEEDED_RESET   = 8'd3;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd500;

  // One decoded frame.
  typedef struct packed {
    logic [PROTO_W-1:0] proto_id;
    logic [CODE_W-1:0]  frame_code;
    logic [BITS_W-1:0]  frame_bits;
    logic [PULSE_W-1:0] pulse_width;
    logic [STAMP_W-1:0] stamp_ms;
  } rcq_frame_t;

  // One qualified report.
  typedef struct packed {
    logic [PROTO_W-1:0] out_proto;
    logic [CODE_W-1:0]  out_code;
    logic [BITS_W-1:0]  out_bits;
    logic [PULSE_W-1:0] avg_pulse;
  } rcq_report_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } rcq_div_stat_t;

endpackage

`default_nettype wire

// ===== src/rcq_divider.sv =====
// ----------------------------------------------------------------------------
// rcq_divider: bit-serial restoring divider
// Produces one quotient bit per cycle; the quotient holds after done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module rcq_divider #(
  parameter int NUM_W = rcq_pkg::DIV_NUM_W,
  parameter int DEN_W = rcq_pkg::DIV_DEN_W
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_W-1:0]    numer,
  input  wire logic [DEN_W-1:0]    denom,
  output rcq_pkg::rcq_div_stat_t   stat,
  output logic      [NUM_W-1:0]    quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] shreg;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DEN_W:0] rem_shift;
  logic [DEN_W:0] trial;
  logic           fits;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    rem_shift = {rem, shreg[NUM_W-1]};
    trial     = rem_shift - {1'b0, den};
    fits      = (rem_shift >= {1'b0, den});
  end

  // Control: iteration counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter the numerator shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= numer;
      rem   <= '0;
      den   <= denom;
    end else if (cnt != '0) begin
      shreg <= {shreg[NUM_W-2:0], fits};
      rem   <= fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quot      = shreg;

endmodule

`default_nettype wire

// ===== src/rf_code_repeat_qualifier.sv =====
// ----------------------------------------------------------------------------
// rf_code_repeat_qualifier: repeat counting and debouncing of radio frames
// Tracks runs of identical frames and reports a qualified, debounced code.
// ----------------------------------------------------------------------------
// A frame that does not complete a run, or that is suppressed by the debounce
// check, is taken in the idle state and the block stays ready. A frame
// that is reported is accepted, and frame_ready stays low while the divider
// is loaded, the bit-serial average divider runs (one quotient bit per
// cycle over the 26-bit numerator 2*sum+n), the divider flags done and the
// result moves into the report register, plus any stall on the report side
// while a previous report still waits.
// Configuration writes are always taken and must only be issued while the
// block is idle.
`default_nettype none

module rf_code_repeat_qualifier (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                frame_valid,
  output logic                                     frame_ready,
  input  wire rcq_pkg::rcq_frame_t                 frame,
  output logic                                     report_valid,
  input  wire logic                                report_ready,
  output rcq_pkg::rcq_report_t                     report,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rcq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } rcq_state_t;

  rcq_state_t state, state_next;

  // Configuration registers.
  logic [rcq_pkg::WINDOW_W-1:0]   repeat_window_ms;
  logic [rcq_pkg::NEEDED_W-1:0]   repeats_needed;
  logic [rcq_pkg::DEBOUNCE_W-1:0] debounce_ms;

  // Run and last-report state.
  logic [rcq_pkg::PROTO_W-1:0] run_proto;
  logic [rcq_pkg::CODE_W-1:0]  run_code;
  logic [rcq_pkg::BITS_W-1:0]  run_bits;
  logic [rcq_pkg::COUNT_W-1:0] run_count;
  logic [rcq_pkg::SUM_W-1:0]   run_pulse_sum;
  logic [rcq_pkg::STAMP_W-1:0] run_time;
  logic [rcq_pkg::PROTO_W-1:0] sent_proto;
  logic [rcq_pkg::CODE_W-1:0]  sent_code;
  logic [rcq_pkg::BITS_W-1:0]  sent_bits;
  logic [rcq_pkg::STAMP_W-1:0] sent_time;

  // Divider operands captured at acceptance.
  logic [rcq_pkg::SUM_W-1:0]   op_sum;
  logic [rcq_pkg::COUNT_W-1:0] op_n;

  logic take;
  logic restart;
  logic hit;
  logic suppress;
  logic fire;
  logic report_free;
  logic [rcq_pkg::STAMP_W-1:0] run_gap;
  logic [rcq_pkg::STAMP_W-1:0] sent_gap;
  logic [rcq_pkg::COUNT_W-1:0] new_count;
  logic [rcq_pkg::SUM_W-1:0]   new_sum;

  logic                              div_start;
  logic [rcq_pkg::DIV_NUM_W-1:0]     div_numer;
  logic [rcq_pkg::DIV_DEN_W-1:0]     div_denom;
  logic [rcq_pkg::DIV_NUM_W-1:0]     div_quot;
  rcq_pkg::rcq_div_stat_t            div_stat;

  assign cfg_ready   = 1'b1;
  assign frame_ready = (state == S_IDLE);
  assign take        = frame_valid && frame_ready;
  assign report_free = !report_valid || report_ready;

  // Run tracking and the debounce decision for the offered frame.
  always_comb begin
    run_gap  = frame.stamp_ms - run_time;
    sent_gap = frame.stamp_ms - sent_time;
    restart  = (frame.frame_code != run_code) || (frame.proto_id != run_proto) ||
               (frame.frame_bits != run_bits) ||
               (run_gap > rcq_pkg::STAMP_W'(repeat_window_ms));
    new_count = (restart ? '0 : run_count) + 1'b1;
    new_sum   = (restart ? '0 : run_pulse_sum) + rcq_pkg::SUM_W'(frame.pulse_width);
    hit       = (new_count >= repeats_needed);
    suppress  = (frame.proto_id == sent_proto) && (frame.frame_code == sent_code) &&
                (frame.frame_bits == sent_bits) &&
                (sent_gap <= rcq_pkg::STAMP_W'(debounce_ms));
    fire      = hit && !suppress;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && fire) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (report_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_window_ms <= rcq_pkg::WINDOW_RESET;
      repeats_needed   <= rcq_pkg::NEEDED_RESET;
      debounce_ms      <= rcq_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcq_pkg::CFG_REPEAT_WINDOW: repeat_window_ms <= cfg_data[rcq_pkg::WINDOW_W-1:0];
        rcq_pkg::CFG_REPEATS_NEEDED: repeats_needed <= cfg_data[rcq_pkg::NEEDED_W-1:0];
        rcq_pkg::CFG_DEBOUNCE:      debounce_ms <= cfg_data[rcq_pkg::DEBOUNCE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Run and last-report state update on each accepted frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_proto     <= '0;
      run_code      <= '0;
      run_bits      <= '0;
      run_count     <= '0;
      run_pulse_sum <= '0;
      run_time      <= '0;
      sent_proto    <= '0;
      sent_code     <= '0;
      sent_bits     <= '0;
      sent_time     <= '0;
    end else if (take) begin
      if (hit) begin
        run_proto     <= '0;
        run_code      <= '0;
        run_bits      <= '0;
        run_count     <= '0;
        run_pulse_sum <= '0;
        run_time      <= '0;
        if (!suppress) begin
          sent_proto <= frame.proto_id;
          sent_code  <= frame.frame_code;
          sent_bits  <= frame.frame_bits;
          sent_time  <= frame.stamp_ms;
        end
      end else begin
        run_proto     <= frame.proto_id;
        run_code      <= frame.frame_code;
        run_bits      <= frame.frame_bits;
        run_count     <= new_count;
        run_pulse_sum <= new_sum;
        run_time      <= frame.stamp_ms;
      end
    end
  end

  // Capture the run totals for the average.
  always_ff @(posedge clk) begin
    if (take && fire) begin
      op_sum <= new_sum;
      op_n   <= new_count;
    end
  end

  // Rounded average: (2*sum + n) / (2*n).
  assign div_start = (state == S_LOAD);
  assign div_numer = {op_sum, 1'b0} + rcq_pkg::DIV_NUM_W'(op_n);
  assign div_denom = {op_n, 1'b0};

  rcq_divider #(
    .NUM_W (rcq_pkg::DIV_NUM_W),
    .DEN_W (rcq_pkg::DIV_DEN_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Report register; the reported frame is the one just recorded as sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (state == S_OUT && report_free) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && report_free) begin
      report.out_proto <= sent_proto;
      report.out_code  <= sent_code;
      report.out_bits  <= sent_bits;
      report.avg_pulse <= div_quot[rcq_pkg::PULSE_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider done outside of the divide state");

  // A frame that is reported starts the divider load next.
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    (take && fire) |=> (state == S_LOAD && !frame_ready))
    else $error("reported frame did not start the average");

  // A run is cleared before its count can reach the wrap value.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count != {rcq_pkg::COUNT_W{1'b1}})
    else $error("run count reached its maximum");

  // The divider is never restarted while it is still busy.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire
